>>> rtl/law_pkg.sv
package law_pkg;

	localparam int GRID_DEF = 16;
	localparam int COORD_W  = 4;
	localparam int SIDE_W   = 5;
	localparam int COUNT_W  = 5;

	localparam logic [SIDE_W-1:0]  SIDE_MIN   = 5'd4;
	localparam logic [SIDE_W-1:0]  SIDE_ABS   = 5'd16;
	localparam logic [COUNT_W-1:0] TARGET_MIN = 5'd2;
	localparam logic [COUNT_W-1:0] TARGET_MAX = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;

	localparam logic [1:0] ACT_SEED  = 2'd0;
	localparam logic [1:0] ACT_SPAWN = 2'd1;
	localparam logic [1:0] ACT_WALK  = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EDGE   = 3'd1;
	localparam logic [2:0] ST_STUCK  = 3'd2;
	localparam logic [2:0] ST_OCC    = 3'd3;
	localparam logic [2:0] ST_REFUSE = 3'd4;

	localparam logic CFG_GRID_SIDE = 1'b0;
	localparam logic CFG_TARGET    = 1'b1;

	typedef struct packed {
		logic [1:0]         action;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic [1:0]         direction;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [COORD_W-1:0] walker_row;
		logic [COORD_W-1:0] walker_col;
		logic [COUNT_W-1:0] particle_count;
		logic               finished;
	} out_t;

	// walker and aggregate bookkeeping
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               active;
		logic [COUNT_W-1:0] count;
	} walk_t;

	// grid write commands for one step
	typedef struct packed {
		logic               clr_all;
		logic               set_en;
		logic [COORD_W-1:0] set_row;
		logic [COORD_W-1:0] set_col;
		logic               clr_en;
		logic [COORD_W-1:0] clr_row;
		logic [COORD_W-1:0] clr_col;
	} upd_t;

endpackage

>>> rtl/lattice_aggregation_walker.sv
// Lattice aggregation walker: runs diffusion-limited aggregation on a square
// occupancy grid held in flip-flops. Each transfer on the input channel carries
// one action (seed, spawn, walk) and yields exactly one result transfer with a
// status code, the walker position, the particle count and a finished flag.
// The block takes one item per clock cycle while the result side does not
// stall. That rate rests on the read-modify-write of the register grid: the
// step logic reads the four neighbours and writes at most two cells (or
// clears the whole grid on a seed) at the edge that loads the result register.
// Each item passes through the input register and then the result register,
// which loads when the step fires. A stalled result holds the step, and the
// input stalls once the input register also holds an item. The user must
// write the grid side and particle target registers through the plain write
// port only while the block is idle; the block itself does not enforce this.
// Out-of-range values saturate to the supported range. Reset clears the grid.
module lattice_aggregation_walker import law_pkg::*; #(
	parameter int GRID_MAX = GRID_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [SIDE_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_t                 in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_t                out_data
);

	// only the first sixteen rows and columns are reachable with 4-bit coordinates
	localparam int GRID_N = (GRID_MAX < 16) ? GRID_MAX : 16;
	localparam logic [SIDE_W-1:0] GRID_LIM = SIDE_W'(GRID_N);

	logic [SIDE_W-1:0]  grid_side_q;
	logic [COUNT_W-1:0] target_q;
	logic [SIDE_W-1:0]  side;
	logic [COUNT_W-1:0] target;

	logic [GRID_N-1:0][GRID_N-1:0] grid_q;
	walk_t walk_q;
	walk_t walk_nxt;
	upd_t  upd;
	out_t  res;

	logic  valid_s1;
	in_t   item_s1;
	logic  out_valid_q;
	out_t  out_q;
	logic  fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_ABS;
			target_q    <= COUNT_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_SIDE: grid_side_q <= cfg_data;
				CFG_TARGET:    target_q    <= cfg_data;
				default:       grid_side_q <= grid_side_q;
			endcase
		end
	end

	// saturate the registers to the usable range
	always_comb begin
		side = grid_side_q;
		if (side > GRID_LIM) begin
			side = GRID_LIM;
		end
		if (side < SIDE_MIN) begin
			side = SIDE_MIN;
		end
		target = target_q;
		if (target > TARGET_MAX) begin
			target = TARGET_MAX;
		end
		if (target < TARGET_MIN) begin
			target = TARGET_MIN;
		end
	end

	// the held item steps when the result register is free or draining
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	// input register: advance on a transfer, drop the valid once stepped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	law_step #(
		.GRID_N (GRID_N)
	) u_step (
		.grid   (grid_q),
		.cur    (walk_q),
		.item   (item_s1),
		.side   (side),
		.target (target),
		.nxt    (walk_nxt),
		.upd    (upd),
		.res    (res)
	);

	// walker state commits with the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (fire) begin
			walk_q <= walk_nxt;
		end
	end

	// grid update: clear everything on a seed, then vacate and mark cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= '0;
		end else if (fire) begin
			for (int r = 0; r < GRID_N; r++) begin
				for (int c = 0; c < GRID_N; c++) begin
					if (upd.set_en && upd.set_row == COORD_W'(r) &&
							upd.set_col == COORD_W'(c)) begin
						grid_q[r][c] <= 1'b1;
					end else if (upd.clr_all) begin
						grid_q[r][c] <= 1'b0;
					end else if (upd.clr_en && upd.clr_row == COORD_W'(r) &&
							upd.clr_col == COORD_W'(c)) begin
						grid_q[r][c] <= 1'b0;
					end
				end
			end
		end
	end

	// result register: hold while stalled, load on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/law_step.sv
module law_step import law_pkg::*; #(
	parameter int GRID_N = GRID_DEF
) (
	input  logic [GRID_N-1:0][GRID_N-1:0] grid,
	input  walk_t                         cur,
	input  in_t                           item,
	input  logic [SIDE_W-1:0]             side,
	input  logic [COUNT_W-1:0]            target,
	output walk_t                         nxt,
	output upd_t                          upd,
	output out_t                          res
);

	localparam int IW = $clog2(GRID_N);
	localparam logic [SIDE_W-1:0] GRID_LIM = SIDE_W'(GRID_N);

	function automatic logic cell_at(input logic [GRID_N-1:0][GRID_N-1:0] g,
			input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
		logic hit;
		hit = 1'b0;
		if ({1'b0, r} < GRID_LIM && {1'b0, c} < GRID_LIM) begin
			hit = g[r[IW-1:0]][c[IW-1:0]];
		end
		return hit;
	endfunction

	logic               in_grid;
	logic               done;
	logic               up_ok, down_ok, left_ok, right_ok;
	logic               touch;
	logic               move_ok;
	logic [COORD_W-1:0] r_up, r_dn, c_lf, c_rt;
	logic [COORD_W-1:0] nr, nc;
	logic [2:0]         status;

	assign in_grid = {1'b0, item.cell_row} < side && {1'b0, item.cell_col} < side;
	assign done    = cur.count >= target;

	assign r_up = cur.row - COORD_W'(1);
	assign r_dn = cur.row + COORD_W'(1);
	assign c_lf = cur.col - COORD_W'(1);
	assign c_rt = cur.col + COORD_W'(1);

	assign up_ok    = cur.row != '0;
	assign down_ok  = ({1'b0, cur.row} + SIDE_W'(1)) < side;
	assign left_ok  = cur.col != '0;
	assign right_ok = ({1'b0, cur.col} + SIDE_W'(1)) < side;

	assign touch = (up_ok && cell_at(grid, r_up, cur.col)) ||
		(down_ok && cell_at(grid, r_dn, cur.col)) ||
		(left_ok && cell_at(grid, cur.row, c_lf)) ||
		(right_ok && cell_at(grid, cur.row, c_rt));

	always_comb begin
		nr      = cur.row;
		nc      = cur.col;
		move_ok = 1'b0;
		unique case (item.direction)
			DIR_UP: begin
				move_ok = up_ok;
				nr      = r_up;
			end
			DIR_DOWN: begin
				move_ok = down_ok;
				nr      = r_dn;
			end
			DIR_LEFT: begin
				move_ok = left_ok;
				nc      = c_lf;
			end
			DIR_RIGHT: begin
				move_ok = right_ok;
				nc      = c_rt;
			end
			default: begin
				move_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		nxt    = cur;
		upd    = '0;
		status = ST_REFUSE;
		unique case (item.action)
			ACT_SEED: begin
				if (in_grid) begin
					upd.clr_all = 1'b1;
					upd.set_en  = 1'b1;
					upd.set_row = item.cell_row;
					upd.set_col = item.cell_col;
					nxt.row     = item.cell_row;
					nxt.col     = item.cell_col;
					nxt.active  = 1'b0;
					nxt.count   = COUNT_W'(1);
					status      = ST_OK;
				end
			end
			ACT_SPAWN: begin
				if (cur.count != '0 && !cur.active && !done && in_grid) begin
					if (cell_at(grid, item.cell_row, item.cell_col)) begin
						status = ST_OCC;
					end else begin
						upd.set_en  = 1'b1;
						upd.set_row = item.cell_row;
						upd.set_col = item.cell_col;
						nxt.row     = item.cell_row;
						nxt.col     = item.cell_col;
						nxt.active  = 1'b1;
						status      = ST_OK;
					end
				end
			end
			ACT_WALK: begin
				if (cur.active) begin
					if (touch) begin
						nxt.active = 1'b0;
						if (cur.count < COUNT_MAX) begin
							nxt.count = cur.count + COUNT_W'(1);
						end
						status = ST_STUCK;
					end else if (move_ok) begin
						upd.clr_en  = 1'b1;
						upd.clr_row = cur.row;
						upd.clr_col = cur.col;
						upd.set_en  = 1'b1;
						upd.set_row = nr;
						upd.set_col = nc;
						nxt.row     = nr;
						nxt.col     = nc;
						status      = ST_OK;
					end else begin
						status = ST_EDGE;
					end
				end
			end
			default: begin
				status = ST_REFUSE;
			end
		endcase
	end

	assign res.status         = status;
	assign res.walker_row     = nxt.row;
	assign res.walker_col     = nxt.col;
	assign res.particle_count = nxt.count;
	assign res.finished       = nxt.count >= target;

endmodule

>>> verif/tb_lattice_aggregation_walker.sv
module tb_lattice_aggregation_walker;
	import law_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Action code that the block must refuse; the package has no name for it.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int ITEM_GOAL = 1450;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [SIDE_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	lattice_aggregation_walker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Shadow of the aggregation state, advanced once per accepted input transfer.
	bit occ [GRID_DEF][GRID_DEF];
	int wk_row, wk_col, fixed_cnt;
	bit wk_active;
	int side_reg, target_reg;
	// Last accepted seed cell; walks are steered toward it so walkers stick.
	int agg_row, agg_col;

	out_t pending_results [$];
	int items_sent;
	int bad_fields = 0;
	int stall_left = 0;
	// Set for whole phases to run with no gaps and no stalls.
	bit calm;

	function automatic int eff_side();
		int s;
		s = side_reg;
		if (s > GRID_DEF) s = GRID_DEF;
		if (s > int'(SIDE_ABS)) s = SIDE_ABS;
		if (s < int'(SIDE_MIN)) s = SIDE_MIN;
		return s;
	endfunction

	function automatic int eff_target();
		int t;
		t = target_reg;
		if (t > int'(TARGET_MAX)) t = TARGET_MAX;
		if (t < int'(TARGET_MIN)) t = TARGET_MIN;
		return t;
	endfunction

	function automatic bit is_occupied(int r, int c);
		if (r < 0 || c < 0 || r >= GRID_DEF || c >= GRID_DEF) return 1'b0;
		return occ[r][c];
	endfunction

	// Advance the shadow state by one action and return the result it yields.
	function automatic out_t aggregate_step(in_t it);
		int side, r, c, nr, nc;
		bit up_ok, down_ok, left_ok, right_ok, touch, ok;
		logic [2:0] st;
		out_t res;
		side = eff_side();
		st = ST_REFUSE;
		r = it.cell_row;
		c = it.cell_col;
		case (it.action)
			ACT_SEED: begin
				if (r < side && c < side) begin
					occ = '{default: 1'b0};
					occ[r][c] = 1'b1;
					wk_row = r;
					wk_col = c;
					agg_row = r;
					agg_col = c;
					wk_active = 1'b0;
					fixed_cnt = 1;
					st = ST_OK;
				end
			end
			ACT_SPAWN: begin
				if (fixed_cnt != 0 && !wk_active && fixed_cnt < eff_target() &&
						r < side && c < side) begin
					if (occ[r][c]) begin
						st = ST_OCC;
					end else begin
						occ[r][c] = 1'b1;
						wk_row = r;
						wk_col = c;
						wk_active = 1'b1;
						st = ST_OK;
					end
				end
			end
			ACT_WALK: begin
				if (wk_active) begin
					r = wk_row;
					c = wk_col;
					// Edge tests use the side in force now, even if the walker lies beyond it.
					up_ok = r > 0;
					down_ok = r + 1 < side;
					left_ok = c > 0;
					right_ok = c + 1 < side;
					touch = (up_ok && is_occupied(r - 1, c)) ||
						(down_ok && is_occupied(r + 1, c)) ||
						(left_ok && is_occupied(r, c - 1)) ||
						(right_ok && is_occupied(r, c + 1));
					if (touch) begin
						wk_active = 1'b0;
						if (fixed_cnt < int'(COUNT_MAX)) fixed_cnt++;
						st = ST_STUCK;
					end else begin
						nr = r;
						nc = c;
						case (it.direction)
							DIR_UP: begin
								ok = up_ok;
								nr = r - 1;
							end
							DIR_DOWN: begin
								ok = down_ok;
								nr = r + 1;
							end
							DIR_LEFT: begin
								ok = left_ok;
								nc = c - 1;
							end
							default: begin
								ok = right_ok;
								nc = c + 1;
							end
						endcase
						if (ok) begin
							occ[r][c] = 1'b0;
							occ[nr][nc] = 1'b1;
							wk_row = nr;
							wk_col = nc;
							st = ST_OK;
						end else begin
							st = ST_EDGE;
						end
					end
				end
			end
			default: ;
		endcase
		res.status = st;
		res.walker_row = COORD_W'(wk_row);
		res.walker_col = COORD_W'(wk_col);
		res.particle_count = COUNT_W'(fixed_cnt);
		res.finished = fixed_cnt >= eff_target();
		return res;
	endfunction

	// Idle length: mostly a few cycles, now and then a long stretch.
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Drive the result-side stall; hold each stall for a run of cycles.
	always @(posedge clk) begin
		if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
			stall_left = idle_len();
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic flag_mismatch(string field, int want, int got);
		bad_fields++;
		if (bad_fields <= REPORT_MAX)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
	endtask

	// Compare every result transfer with the oldest pending expectation.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result, status", -1, out_data.status);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status)
					flag_mismatch("status", want.status, out_data.status);
				if (out_data.walker_row !== want.walker_row)
					flag_mismatch("walker_row", want.walker_row, out_data.walker_row);
				if (out_data.walker_col !== want.walker_col)
					flag_mismatch("walker_col", want.walker_col, out_data.walker_col);
				if (out_data.particle_count !== want.particle_count)
					flag_mismatch("particle_count", want.particle_count,
						out_data.particle_count);
				if (out_data.finished !== want.finished)
					flag_mismatch("finished", want.finished, out_data.finished);
			end
		end
	end

	// Present one item after a random gap and hold it until the transfer happens.
	// Valid is left high afterwards so back-to-back items need no second drive.
	task automatic send_item(logic [1:0] act, int row, int col, logic [1:0] dir);
		in_t it;
		int gap;
		it.action = act;
		it.cell_row = COORD_W'(row);
		it.cell_col = COORD_W'(col);
		it.direction = dir;
		gap = 0;
		if (!calm && $urandom_range(0, 99) >= 55) gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(aggregate_step(it));
		items_sent++;
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write both registers on consecutive edges, only with the block idle.
	task automatic set_config(int side, int target);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRID_SIDE;
		cfg_data <= SIDE_W'(side);
		@(posedge clk);
		cfg_index <= CFG_TARGET;
		cfg_data <= SIDE_W'(target);
		@(posedge clk);
		cfg_we <= 1'b0;
		side_reg = side & 31;
		target_reg = target & 31;
	endtask

	// Nothing is seeded yet: spawn, walk and the unused code are all refused.
	task automatic test_refusals_after_reset();
		send_item(ACT_SPAWN, 0, 0, DIR_UP);
		send_item(ACT_WALK, 15, 15, DIR_DOWN);
		send_item(ACT_UNUSED, 5, 10, DIR_RIGHT);
		send_item(ACT_SEED, 15, 15, DIR_LEFT);
	endtask

	// Full grid: occupied spawn, spawn while active, edge blocks and plain moves.
	task automatic test_seed_spawn_walk();
		send_item(ACT_SPAWN, 15, 15, DIR_UP);
		send_item(ACT_SPAWN, 0, 0, DIR_UP);
		send_item(ACT_SPAWN, 5, 5, DIR_UP);
		send_item(ACT_WALK, 0, 0, DIR_UP);
		send_item(ACT_WALK, 0, 0, DIR_LEFT);
		send_item(ACT_WALK, 0, 0, DIR_RIGHT);
		send_item(ACT_WALK, 0, 0, DIR_DOWN);
	endtask

	// Smallest grid, smallest target: out-of-grid seeds, a walk that sticks, and
	// a spawn refused once the target is met.
	task automatic test_small_grid_sticking();
		set_config(4, 2);
		send_item(ACT_SEED, 4, 0, DIR_UP);
		send_item(ACT_SEED, 0, 4, DIR_UP);
		send_item(ACT_SEED, 3, 3, DIR_UP);
		send_item(ACT_SPAWN, 0, 0, DIR_UP);
		send_item(ACT_WALK, 0, 0, DIR_RIGHT);
		send_item(ACT_WALK, 0, 0, DIR_RIGHT);
		send_item(ACT_WALK, 0, 0, DIR_DOWN);
		send_item(ACT_WALK, 0, 0, DIR_DOWN);
		send_item(ACT_WALK, 0, 0, DIR_RIGHT);
		send_item(ACT_WALK, 0, 0, DIR_LEFT);
		send_item(ACT_SPAWN, 0, 0, DIR_UP);
	endtask

	// Shrink the side under a walker: down and right are blocked, up still moves.
	task automatic test_shrunk_side();
		set_config(16, 16);
		send_item(ACT_SEED, 0, 0, DIR_UP);
		send_item(ACT_SPAWN, 9, 5, DIR_UP);
		set_config(4, 16);
		send_item(ACT_WALK, 0, 0, DIR_DOWN);
		send_item(ACT_WALK, 0, 0, DIR_RIGHT);
		send_item(ACT_WALK, 0, 0, DIR_UP);
	endtask

	task automatic plant_seed();
		int side;
		side = eff_side();
		if ($urandom_range(0, 9) == 0)
			send_item(ACT_SEED, $urandom_range(0, 15), $urandom_range(0, 15),
				2'($urandom_range(0, 3)));
		else
			send_item(ACT_SEED, $urandom_range(0, side - 1), $urandom_range(0, side - 1),
				2'($urandom_range(0, 3)));
	endtask

	// Mostly aim at a free cell; now and then send whatever comes up.
	task automatic spawn_walker();
		int side, r, c, tries;
		side = eff_side();
		r = $urandom_range(0, 15);
		c = $urandom_range(0, 15);
		if ($urandom_range(0, 19) != 0) begin
			tries = 0;
			do begin
				r = $urandom_range(0, side - 1);
				c = $urandom_range(0, side - 1);
				tries++;
			end while (is_occupied(r, c) && tries < 8);
		end
		send_item(ACT_SPAWN, r, c, 2'($urandom_range(0, 3)));
	endtask

	// Steer toward the seed most of the time so the walker reaches the aggregate.
	task automatic step_walker();
		int dr, dc;
		logic [1:0] dir;
		dr = agg_row - wk_row;
		dc = agg_col - wk_col;
		dir = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) < 7 && (dr != 0 || dc != 0)) begin
			if (dr != 0 && (dc == 0 || $urandom_range(0, 1) == 1))
				dir = (dr < 0) ? DIR_UP : DIR_DOWN;
			else
				dir = (dc < 0) ? DIR_LEFT : DIR_RIGHT;
		end
		send_item(ACT_WALK, $urandom_range(0, 15), $urandom_range(0, 15), dir);
	endtask

	// Seed, then spawn and walk until the target is met or the budget runs out.
	task automatic grow_cluster(int budget);
		int steps;
		bit over;
		plant_seed();
		over = 1'b0;
		for (steps = 0; steps < budget && !over && items_sent < ITEM_GOAL; steps++) begin
			if (fixed_cnt == 0 || $urandom_range(0, 99) < 2) begin
				plant_seed();
			end else if ($urandom_range(0, 99) < 5) begin
				send_item(2'($urandom_range(0, 3)), $urandom_range(0, 15),
					$urandom_range(0, 15), 2'($urandom_range(0, 3)));
			end else if (!wk_active) begin
				// Once finished, one more spawn shows the refusal and ends the cluster.
				over = fixed_cnt >= eff_target();
				spawn_walker();
			end else begin
				step_walker();
			end
		end
	endtask

	task automatic test_random_aggregation();
		int phase, side, target, p;
		int side_ext [6] = '{0, 31, 4, 16, 3, 17};
		int target_ext [6] = '{31, 0, 2, 16, 1, 17};
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			if (phase < 6) begin
				side = side_ext[phase];
				target = target_ext[phase];
			end else begin
				// Keep most grids small so clusters finish in few steps.
				p = $urandom_range(0, 9);
				side = (p < 7) ? $urandom_range(4, 6) :
					(p < 9) ? $urandom_range(7, 16) : $urandom_range(0, 31);
				target = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 6) :
					$urandom_range(0, 31);
			end
			set_config(side, target);
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) grow_cluster(400);
			phase++;
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GRID_SIDE;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		items_sent = 0;
		occ = '{default: 1'b0};
		wk_row = 0;
		wk_col = 0;
		wk_active = 1'b0;
		fixed_cnt = 0;
		agg_row = 0;
		agg_col = 0;
		side_reg = 16;
		target_reg = 4;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_refusals_after_reset();
		test_seed_spawn_walk();
		test_small_grid_sticking();
		test_shrunk_side();
		test_random_aggregation();

		// Let the last results drain, then watch a little longer for strays.
		wait_idle();
		repeat (10) @(posedge clk);
		if (bad_fields == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
